@@ sv/pmwq_pkg.sv @@
// Shared types, codes and default sizes for the priority mutex wait queue.
package pmwq_pkg;

   localparam int MAX_WAITERS_DEF   = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   localparam logic [1:0] OP_CLAIM    = 2'd0;
   localparam logic [1:0] OP_RELEASE  = 2'd1;
   localparam logic [1:0] OP_WITHDRAW = 2'd2;

   localparam logic [2:0] ST_GRANTED     = 3'd0;
   localparam logic [2:0] ST_BLOCKED     = 3'd1;
   localparam logic [2:0] ST_FREED       = 3'd2;
   localparam logic [2:0] ST_HANDED      = 3'd3;
   localparam logic [2:0] ST_WITHDRAWN   = 3'd4;
   localparam logic [2:0] ST_NOT_WAITING = 3'd5;
   localparam logic [2:0] ST_REJECTED    = 3'd6;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] task_id;
      logic [7:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] woken_task;
      logic [7:0] ceiling_priority;
      logic [4:0] waiter_count;
   } rsp_type;

   // Broadcast controls from the sequencer to every cell of the list.
   typedef struct packed {
      logic       push;         // shift all entries one place away from the head
      logic       remove;       // close the gap at the selected entry
      logic       use_cand;     // select by search candidate rather than task match
      logic       cand_init;    // start a maximum search over the valid entries
      logic       search_step;  // narrow the candidates by one level bit
      logic [3:0] task_id;      // task to match against
   } cell_ctrl_type;

endpackage

@@ sv/pmwq_cell.sv @@
// One wait-list entry with its share of the search, match and shift logic.
module pmwq_cell #(
   parameter  int LEVEL_W = pmwq_pkg::PRIORITY_BITS_DEF,
   localparam int IDX_W   = (LEVEL_W > 1) ? $clog2(LEVEL_W) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pmwq_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]        bit_idx,
   input  logic                    any_bit,
   input  logic                    left_valid,
   input  logic [3:0]              left_task,
   input  logic [LEVEL_W-1:0]      left_level,
   input  logic                    right_valid,
   input  logic [3:0]              right_task,
   input  logic [LEVEL_W-1:0]      right_level,
   input  logic                    after_in,
   output logic                    after_out,
   output logic                    valid_out,
   output logic [3:0]              task_out,
   output logic [LEVEL_W-1:0]      level_out,
   output logic                    bit_out,
   output logic [3:0]              woken_part
);

   logic               valid_ff, valid_in;
   logic [3:0]         task_ff, task_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               cand_ff, cand_in;
   logic               sel;
   logic               first;

   // The selection is carried along the row so that every entry at or after
   // the chosen one knows to take its neighbour's contents on a removal.
   assign sel       = ctrl.use_cand ? cand_ff : (valid_ff && (task_ff == ctrl.task_id));
   assign after_out = after_in | sel;
   assign first     = sel & ~after_in;

   assign valid_out  = valid_ff;
   assign task_out   = task_ff;
   assign level_out  = level_ff;
   assign bit_out    = cand_ff & level_ff[bit_idx];
   assign woken_part = first ? task_ff : 4'd0;

   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      level_in = level_ff;
      if (ctrl.push) begin
         valid_in = left_valid;
         task_in  = left_task;
         level_in = left_level;
      end else if (ctrl.remove && after_out) begin
         valid_in = right_valid;
         task_in  = right_task;
         level_in = right_level;
      end

      cand_in = cand_ff;
      if (ctrl.cand_init) begin
         cand_in = valid_ff;
      end else if (ctrl.search_step && any_bit) begin
         cand_in = cand_ff & level_ff[bit_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cand_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         cand_ff  <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff  <= task_in;
      level_ff <= level_in;
   end

endmodule

@@ sv/pmwq_chain.sv @@
// Row of wait-list cells, with the head fed by a new claimant.
module pmwq_chain #(
   parameter  int MAX_WAITERS   = pmwq_pkg::MAX_WAITERS_DEF,
   parameter  int PRIORITY_BITS = pmwq_pkg::PRIORITY_BITS_DEF,
   localparam int IDX_W         = (PRIORITY_BITS > 1) ? $clog2(PRIORITY_BITS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pmwq_pkg::cell_ctrl_type  ctrl,
   input  logic [IDX_W-1:0]         bit_idx,
   input  logic [3:0]               new_task,
   input  logic [PRIORITY_BITS-1:0] new_level,
   output logic                     found,
   output logic [3:0]               woken_task
);

   logic                     valid_w   [MAX_WAITERS];
   logic [3:0]               task_w    [MAX_WAITERS];
   logic [PRIORITY_BITS-1:0] level_w   [MAX_WAITERS];
   logic [3:0]               woken_w   [MAX_WAITERS];
   logic [MAX_WAITERS-1:0]   bit_w;
   logic [MAX_WAITERS:0]     after_w;
   logic                     any_bit;

   assign after_w[0] = 1'b0;
   assign any_bit    = |bit_w;
   // With task matching this is true when the task is anywhere in the list.
   assign found      = after_w[MAX_WAITERS];

   always_comb begin
      woken_task = 4'd0;
      for (int i = 0; i < MAX_WAITERS; i++) begin
         woken_task = woken_task | woken_w[i];
      end
   end

   for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
      logic                     l_valid, r_valid;
      logic [3:0]               l_task, r_task;
      logic [PRIORITY_BITS-1:0] l_level, r_level;

      if (i == 0) begin : g_head
         assign l_valid = 1'b1;
         assign l_task  = new_task;
         assign l_level = new_level;
      end else begin : g_body
         assign l_valid = valid_w[i-1];
         assign l_task  = task_w[i-1];
         assign l_level = level_w[i-1];
      end

      if (i == MAX_WAITERS - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_task  = 4'd0;
         assign r_level = '0;
      end else begin : g_inner
         assign r_valid = valid_w[i+1];
         assign r_task  = task_w[i+1];
         assign r_level = level_w[i+1];
      end

      pmwq_cell #(
         .LEVEL_W (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .bit_idx     (bit_idx),
         .any_bit     (any_bit),
         .left_valid  (l_valid),
         .left_task   (l_task),
         .left_level  (l_level),
         .right_valid (r_valid),
         .right_task  (r_task),
         .right_level (r_level),
         .after_in    (after_w[i]),
         .after_out   (after_w[i+1]),
         .valid_out   (valid_w[i]),
         .task_out    (task_w[i]),
         .level_out   (level_w[i]),
         .bit_out     (bit_w[i]),
         .woken_part  (woken_w[i])
      );
   end

endmodule

@@ sv/priority_mutex_wait_queue.sv @@
// Top level of the priority mutex wait queue: sequencer, mutex state and response register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  pmwq_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall  pmwq_pkg::rsp_type
//
// Claim and withdraw capture the request in S_IDLE and update the list in
// S_APPLY. A release with waiters passes through S_SEARCH in between, as the
// maximum search across the cells settles one level bit per cycle, MSB first.
// One request is in progress at a time; a new one is accepted while the
// previous response still waits in the output register.
// A stalled response holds the update cycle until the register is free.
// Reset is synchronous and empties the list, frees the mutex and zeroes the ceiling.
module priority_mutex_wait_queue #(
   parameter int MAX_WAITERS   = pmwq_pkg::MAX_WAITERS_DEF,
   parameter int PRIORITY_BITS = pmwq_pkg::PRIORITY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pmwq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pmwq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_WAITERS + 1);
   localparam int IDX_W = (PRIORITY_BITS > 1) ? $clog2(PRIORITY_BITS) : 1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_APPLY  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   pmwq_pkg::req_type        req_ff;
   logic [IDX_W-1:0]         bit_ff, bit_in;
   logic                     taken_ff, taken_in;
   logic [PRIORITY_BITS-1:0] ceiling_ff, ceiling_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pmwq_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   pmwq_pkg::cell_ctrl_type  ctrl;
   logic                     accept;
   logic                     commit;
   logic                     found;
   logic [3:0]               woken;
   logic [PRIORITY_BITS-1:0] req_level;
   logic [2:0]               status;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_level = req_ff.priority_req[PRIORITY_BITS-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pmwq_chain #(
      .MAX_WAITERS   (MAX_WAITERS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .bit_idx    (bit_ff),
      .new_task   (req_ff.task_id),
      .new_level  (req_level),
      .found      (found),
      .woken_task (woken)
   );

   always_comb begin
      state_in   = state_ff;
      bit_in     = bit_ff;
      taken_in   = taken_ff;
      ceiling_in = ceiling_ff;
      count_in   = count_ff;
      status     = pmwq_pkg::ST_REJECTED;

      ctrl             = '0;
      ctrl.task_id     = req_ff.task_id;
      ctrl.use_cand    = (req_ff.opcode == pmwq_pkg::OP_RELEASE);
      // Candidates are loaded on every accepted request; only a release uses them.
      ctrl.cand_init   = accept;
      ctrl.search_step = (state_ff == S_SEARCH);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               bit_in = IDX_W'(PRIORITY_BITS - 1);
               if ((req_data.opcode == pmwq_pkg::OP_RELEASE) && (count_ff != '0)) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SEARCH: begin
            if (bit_ff == '0) begin
               state_in = S_APPLY;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         S_APPLY: begin
            case (req_ff.opcode)
               pmwq_pkg::OP_CLAIM: begin
                  if (!taken_ff) begin
                     taken_in   = 1'b1;
                     ceiling_in = req_level;
                     status     = pmwq_pkg::ST_GRANTED;
                  end else if (found || (count_ff == CNT_W'(MAX_WAITERS))) begin
                     status = pmwq_pkg::ST_REJECTED;
                  end else begin
                     ctrl.push = commit;
                     count_in  = count_ff + 1'b1;
                     if (req_level > ceiling_ff) begin
                        ceiling_in = req_level;
                     end
                     status = pmwq_pkg::ST_BLOCKED;
                  end
               end
               pmwq_pkg::OP_RELEASE: begin
                  if (count_ff == '0) begin
                     taken_in = 1'b0;
                     status   = pmwq_pkg::ST_FREED;
                  end else begin
                     ctrl.remove = commit;
                     taken_in    = 1'b1;
                     count_in    = count_ff - 1'b1;
                     status      = pmwq_pkg::ST_HANDED;
                  end
               end
               pmwq_pkg::OP_WITHDRAW: begin
                  if (found) begin
                     ctrl.remove = commit;
                     count_in    = count_ff - 1'b1;
                     status      = pmwq_pkg::ST_WITHDRAWN;
                  end else begin
                     status = pmwq_pkg::ST_NOT_WAITING;
                  end
               end
               default: begin
                  status = pmwq_pkg::ST_REJECTED;
               end
            endcase
            if (commit) begin
               state_in = S_IDLE;
            end else begin
               taken_in   = taken_ff;
               ceiling_in = ceiling_ff;
               count_in   = count_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in.status           = status;
      rsp_data_in.woken_task       = (status == pmwq_pkg::ST_HANDED) ? woken : 4'd0;
      rsp_data_in.ceiling_priority = 8'(ceiling_in);
      rsp_data_in.waiter_count     = 5'(count_in);

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_ff       <= '0;
         taken_ff     <= 1'b0;
         ceiling_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         taken_ff     <= taken_in;
         ceiling_ff   <= ceiling_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
